/* rtl/htd_pkg.sv */
package htd_pkg;

  localparam int MAX_NODES   = 512;
  localparam int STACK_DEPTH = 256;

  localparam int NODE_AW  = $clog2(MAX_NODES);
  localparam int NODE_CW  = NODE_AW + 1;
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int STACK_CW = STACK_AW + 1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TREE  = 2'd1,
    CMD_BIT   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_SYMBOL    = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_NOT_READY = 2'd2
  } status_t;

  // left child of a branch is always the next node in preorder, so only the
  // right child is stored
  typedef struct packed {
    logic               leaf;
    logic [7:0]         sym;
    logic [NODE_AW-1:0] right;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic               en;
    logic [NODE_AW-1:0] addr;
    node_t              data;
  } node_wr_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] symbol;
    logic       last;
    status_t    status;
  } result_t;

endpackage

/* rtl/htd_ram.sv */
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/htd_builder.sv */
module htd_builder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_go,
  input  logic              tree_go,
  input  logic [7:0]        tree_byte,
  output htd_pkg::node_wr_t node_wr,
  output logic              tree_err,
  output logic              tree_ready
);

  logic [htd_pkg::STACK_CW-1:0] top_r, top_nxt;
  logic [htd_pkg::NODE_CW-1:0]  free_r, free_nxt;
  logic [htd_pkg::NODE_AW-1:0]  pend_parent_r, pend_parent_nxt, pend_parent_eff;
  logic                         pend_right_r, pend_right_nxt, pend_right_eff;
  logic                         expect_r, expect_nxt;
  logic                         ready_r, ready_nxt;
  logic                         pop_pend_r, pop_pend_nxt;

  logic                         stk_wr_en;
  logic [htd_pkg::STACK_AW-1:0] stk_wr_addr;
  logic [htd_pkg::NODE_AW-1:0]  stk_wr_data;
  logic                         stk_rd_en;
  logic [htd_pkg::STACK_AW-1:0] stk_rd_addr;
  logic [htd_pkg::NODE_AW-1:0]  stk_rd_data;

  // the stack holds parents whose right slot is still open
  htd_ram #(
    .WIDTH (htd_pkg::NODE_AW),
    .DEPTH (htd_pkg::STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  // popped slot comes from the stack's registered read, forward it to the next tree byte
  assign pend_parent_eff = pop_pend_r ? stk_rd_data : pend_parent_r;
  assign pend_right_eff  = pop_pend_r | pend_right_r;

  always_comb begin
    top_nxt         = top_r;
    free_nxt        = free_r;
    pend_parent_nxt = pend_parent_eff;
    pend_right_nxt  = pend_right_eff;
    expect_nxt      = expect_r;
    ready_nxt       = ready_r;
    pop_pend_nxt    = 1'b0;
    node_wr         = '0;
    tree_err        = 1'b0;
    stk_wr_en       = 1'b0;
    stk_wr_addr     = htd_pkg::STACK_AW'(top_r);
    stk_wr_data     = htd_pkg::NODE_AW'(free_r);
    stk_rd_en       = 1'b0;
    stk_rd_addr     = htd_pkg::STACK_AW'(top_r - htd_pkg::STACK_CW'(1));
    if (start_go) begin
      top_nxt         = '0;
      free_nxt        = '0;
      pend_parent_nxt = '0;
      pend_right_nxt  = 1'b0;
      expect_nxt      = 1'b0;
      ready_nxt       = 1'b0;
    end else if (tree_go && !ready_r) begin
      if (expect_r) begin
        // leaf entry is written once its symbol is known
        node_wr.en         = 1'b1;
        node_wr.addr       = htd_pkg::NODE_AW'(free_r - htd_pkg::NODE_CW'(1));
        node_wr.data.leaf  = 1'b1;
        node_wr.data.sym   = tree_byte;
        node_wr.data.right = '0;
        expect_nxt         = 1'b0;
        if (top_r == '0) begin
          ready_nxt = 1'b1;
        end else begin
          top_nxt      = top_r - htd_pkg::STACK_CW'(1);
          stk_rd_en    = 1'b1;
          pop_pend_nxt = 1'b1;
        end
      end else if (free_r >= htd_pkg::NODE_CW'(htd_pkg::MAX_NODES) ||
                   (tree_byte == 8'd0 &&
                    top_r >= htd_pkg::STACK_CW'(htd_pkg::STACK_DEPTH))) begin
        tree_err = 1'b1;
      end else begin
        // a branch entry is complete once its right child is linked
        if (pend_right_eff) begin
          node_wr.en         = 1'b1;
          node_wr.addr       = pend_parent_eff;
          node_wr.data.leaf  = 1'b0;
          node_wr.data.sym   = 8'd0;
          node_wr.data.right = htd_pkg::NODE_AW'(free_r);
        end
        free_nxt = free_r + htd_pkg::NODE_CW'(1);
        if (tree_byte == 8'd0) begin
          stk_wr_en       = 1'b1;
          top_nxt         = top_r + htd_pkg::STACK_CW'(1);
          pend_right_nxt  = 1'b0;
          pend_parent_nxt = htd_pkg::NODE_AW'(free_r);
        end else begin
          expect_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r         <= '0;
      free_r        <= '0;
      pend_parent_r <= '0;
      pend_right_r  <= 1'b0;
      expect_r      <= 1'b0;
      ready_r       <= 1'b0;
      pop_pend_r    <= 1'b0;
    end else begin
      top_r         <= top_nxt;
      free_r        <= free_nxt;
      pend_parent_r <= pend_parent_nxt;
      pend_right_r  <= pend_right_nxt;
      expect_r      <= expect_nxt;
      ready_r       <= ready_nxt;
      pop_pend_r    <= pop_pend_nxt;
    end
  end

  assign tree_ready = ready_r;

endmodule

/* rtl/htd_walker.sv */
module htd_walker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_go,
  input  logic                        bit_go,
  input  logic                        coded_bit,
  input  logic [31:0]                 symbol_total,
  input  logic                        tree_ready,
  input  htd_pkg::node_wr_t           node_wr,
  output logic                        rd_en,
  output logic [htd_pkg::NODE_AW-1:0] rd_addr,
  input  htd_pkg::node_t              rd_data,
  output logic                        busy,
  output htd_pkg::result_t            res
);

  logic [31:0]                 left_r, left_nxt;
  logic                        at_root_r, at_root_nxt;
  logic                        walk_pend_r;
  logic [htd_pkg::NODE_AW-1:0] cur_idx_r, cur_right_r, next_r;
  htd_pkg::node_t              root_r;

  logic                        cur_leaf;
  logic [htd_pkg::NODE_AW-1:0] cur_idx, cur_right, next_idx;
  logic [htd_pkg::NODE_CW-1:0] cand;
  logic                        walk_go;

  // a copy of the root entry saves a read on every return to the root
  always_ff @(posedge clk) begin
    if (node_wr.en && node_wr.addr == '0) begin
      root_r <= node_wr.data;
    end
  end

  assign cur_leaf  = at_root_r & root_r.leaf;
  assign cur_right = at_root_r ? root_r.right : cur_right_r;
  assign cur_idx   = at_root_r ? '0 : cur_idx_r;

  always_comb begin
    if (coded_bit) begin
      cand = {1'b0, cur_right};
    end else begin
      cand = {1'b0, cur_idx} + htd_pkg::NODE_CW'(1);
    end
    // a leaf root points back to itself
    if (cur_leaf || cand >= htd_pkg::NODE_CW'(htd_pkg::MAX_NODES)) begin
      next_idx = '0;
    end else begin
      next_idx = cand[htd_pkg::NODE_AW-1:0];
    end
  end

  assign walk_go = bit_go && left_r != 32'd0 && tree_ready;
  assign rd_en   = walk_go;
  assign rd_addr = next_idx;
  assign busy    = walk_pend_r;

  always_comb begin
    left_nxt    = left_r;
    at_root_nxt = at_root_r;
    res         = '0;
    res.status  = htd_pkg::ST_SYMBOL;
    if (start_go) begin
      left_nxt    = symbol_total;
      at_root_nxt = 1'b1;
    end else if (walk_pend_r) begin
      if (rd_data.leaf) begin
        res.valid   = 1'b1;
        res.symbol  = rd_data.sym;
        res.last    = (left_r == 32'd1);
        left_nxt    = left_r - 32'd1;
        at_root_nxt = 1'b1;
      end else begin
        at_root_nxt = 1'b0;
      end
    end else if (bit_go && left_r != 32'd0 && !tree_ready) begin
      res.valid  = 1'b1;
      res.status = htd_pkg::ST_NOT_READY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      at_root_r   <= 1'b1;
      walk_pend_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      at_root_r   <= at_root_nxt;
      walk_pend_r <= walk_go;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_go) begin
      next_r <= next_idx;
    end
    if (walk_pend_r && !rd_data.leaf) begin
      cur_idx_r   <= next_r;
      cur_right_r <= rd_data.right;
    end
  end

endmodule

/* rtl/huffman_tree_decoder.sv */
// Huffman decoder that rebuilds a code tree from its preorder serialization
// and walks it one coded bit per item. Start items and tree bytes are taken
// one per cycle if not stalled. A coded bit stalls the input: its child lookup
// reads the node memory, whose registered read decides the next node before the
// following bit may enter. Node memory has MAX_NODES entries, the pending-slot
// stack STACK_DEPTH entries; neither is cleared after reset, since the builder
// writes every node a finished tree uses. Results leave through an output
// register and overflow or early-bit errors come back in place of a symbol.
module huffman_tree_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_symbol_total,
  input  logic [7:0]  in_tree_byte,
  input  logic        in_coded_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_symbol,
  output logic        out_last,
  output logic [1:0]  out_status
);

  logic                        in_go;
  logic                        start_go, tree_go, bit_go;
  htd_pkg::node_wr_t           node_wr;
  logic                        tree_err, tree_ready;
  logic                        rd_en;
  logic [htd_pkg::NODE_AW-1:0] rd_addr;
  logic [htd_pkg::NODE_W-1:0]  rd_data;
  logic                        walk_busy;
  htd_pkg::result_t            walk_res;
  logic                        load;

  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_symbol_r;
  logic                        out_last_r;
  logic [1:0]                  out_status_r;

  assign in_stall = walk_busy | (out_valid_r & out_stall);
  assign in_go    = in_valid & ~in_stall;

  always_comb begin
    start_go = 1'b0;
    tree_go  = 1'b0;
    bit_go   = 1'b0;
    unique case (htd_pkg::cmd_t'(in_command))
      htd_pkg::CMD_START: start_go = in_go;
      htd_pkg::CMD_TREE:  tree_go  = in_go;
      htd_pkg::CMD_BIT:   bit_go   = in_go;
      default: ;
    endcase
  end

  htd_builder u_builder (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_go   (start_go),
    .tree_go    (tree_go),
    .tree_byte  (in_tree_byte),
    .node_wr    (node_wr),
    .tree_err   (tree_err),
    .tree_ready (tree_ready)
  );

  htd_ram #(
    .WIDTH (htd_pkg::NODE_W),
    .DEPTH (htd_pkg::MAX_NODES)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (node_wr.en),
    .wr_addr (node_wr.addr),
    .wr_data (node_wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  htd_walker u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_go     (start_go),
    .bit_go       (bit_go),
    .coded_bit    (in_coded_bit),
    .symbol_total (in_symbol_total),
    .tree_ready   (tree_ready),
    .node_wr      (node_wr),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .busy         (walk_busy),
    .res          (walk_res)
  );

  assign load          = tree_err | walk_res.valid;
  assign out_valid_nxt = load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tree_err) begin
      out_symbol_r <= 8'd0;
      out_last_r   <= 1'b0;
      out_status_r <= htd_pkg::ST_OVERFLOW;
    end else if (walk_res.valid) begin
      out_symbol_r <= walk_res.symbol;
      out_last_r   <= walk_res.last;
      out_status_r <= walk_res.status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

`ifndef ASSERT_OFF
  // a new result only lands in a free or draining output register
  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !(out_valid_r && out_stall))
    else $error("result written over a held item");

  // the node lookup of one bit resolves before another item enters
  assert property (@(posedge clk) disable iff (!rst_n)
    walk_busy |=> !walk_busy)
    else $error("walk lookup overlapped");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(tree_err && walk_res.valid))
    else $error("two results in one cycle");

  // the node memory is never written while a walk reads it
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !node_wr.en)
    else $error("node write during walk");
`endif

endmodule
